// File: rtl/fda_pkg.sv
// Package for the FLV demultiplexer: parse phases, result record and front/back command type.
// No dependencies.
package fda_pkg;

   typedef enum logic [3:0] {
      PH_FILE_HDR, PH_PREV_SIZE, PH_TAG_HDR, PH_SKIP, PH_VID_HEAD, PH_CFG_HEAD,
      PH_CFG_SPS, PH_CFG_PPS_HEAD, PH_CFG_PPS, PH_NAL_LEN, PH_NAL_DATA,
      PH_AUD_HEAD, PH_AUD_CFG, PH_AUD_DATA
   } phase_type;

   typedef enum logic [1:0] {
      CMD_BYTE, CMD_START, CMD_ADTS
   } cmd_kind_type;

   // One classified request handed from the parser to the emitter
   typedef struct packed {
      cmd_kind_type kind;
      logic         stream;
      logic [7:0]   data;
      logic [31:0]  dts;
      logic [23:0]  cts;
      logic [1:0]   profile;
      logic [3:0]   rate_index;
      logic [2:0]   channels;
      logic [12:0]  adts_len;
   } cmd_type;

   localparam int unsigned ADTS_BYTES  = 7;
   localparam int unsigned START_BYTES = 4;
   localparam logic [7:0]  TAG_VIDEO   = 8'd9;
   localparam logic [7:0]  TAG_AUDIO   = 8'd8;
   localparam logic [3:0]  CODEC_AVC   = 4'd7;
   localparam logic [3:0]  FMT_AAC     = 4'd10;

   // register indexes on the csr port
   localparam logic [0:0]  CSR_VIDEO_EN = 1'd0;
   localparam logic [0:0]  CSR_AUDIO_EN = 1'd1;

endpackage

// File: rtl/fda_parse.sv
// Front end: parses FLV bytes and issues one emit command per request that yields output.
// Depends on fda_pkg.
module fda_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        byte_data,
   input  logic              video_enable,
   input  logic              audio_enable,
   output logic              cmd_valid,
   output fda_pkg::cmd_type  cmd
);

   fda_pkg::phase_type phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] hdr_len_ff, hdr_len_in;
   logic [7:0]  tag_kind_ff, tag_kind_in;
   logic [23:0] tag_len_ff, tag_len_in;
   logic [31:0] tag_time_ff, tag_time_in;
   logic [7:0]  pkt_ff, pkt_in;
   logic [23:0] comp_ff, comp_in;
   logic [2:0]  nal_bytes_ff, nal_bytes_in;
   logic [31:0] nal_rem_ff, nal_rem_in;
   logic [15:0] ps_len_ff, ps_len_in;
   logic [1:0]  prof_ff, prof_in;
   logic [3:0]  rate_ff, rate_in;
   logic [2:0]  chan_ff, chan_in;
   logic [2:0]  sub_ff, sub_in;
   logic [31:0] count_inc;
   logic [31:0] nal_shift;
   logic [15:0] ps_full;
   logic [2:0]  sub_inc;
   logic        body;

   always_comb begin
      phase_in = phase_ff; count_in = count_ff; hdr_len_in = hdr_len_ff;
      tag_kind_in = tag_kind_ff; tag_len_in = tag_len_ff; tag_time_in = tag_time_ff;
      pkt_in = pkt_ff; comp_in = comp_ff; nal_bytes_in = nal_bytes_ff;
      nal_rem_in = nal_rem_ff; ps_len_in = ps_len_ff; prof_in = prof_ff;
      rate_in = rate_ff; chan_in = chan_ff; sub_in = sub_ff;
      cmd_valid = 1'b0;
      cmd.kind = fda_pkg::CMD_BYTE;
      cmd.stream = 1'b0;
      cmd.data = byte_data;
      cmd.dts = tag_time_ff;
      cmd.cts = comp_ff;
      cmd.profile = prof_ff;
      cmd.rate_index = rate_ff;
      cmd.channels = chan_ff;
      cmd.adts_len = 13'(tag_len_ff + 24'd5);
      count_inc = count_ff + 32'd1;
      nal_shift = {nal_rem_ff[23:0], byte_data};
      ps_full = {ps_len_ff[7:0], byte_data};
      sub_inc = sub_ff + 3'd1;
      body = 1'b0;
      if (byte_valid) begin
         case (phase_ff)
            fda_pkg::PH_FILE_HDR: begin
               if (count_ff >= 32'd5 && count_ff <= 32'd8)
                  hdr_len_in = {hdr_len_ff[23:0], byte_data};
               count_in = count_inc;
               if (count_inc >= 32'd9 && count_inc >= hdr_len_in) begin
                  phase_in = fda_pkg::PH_PREV_SIZE; count_in = '0;
               end
            end
            fda_pkg::PH_PREV_SIZE: begin
               count_in = count_inc;
               if (count_inc >= 32'd4) begin
                  phase_in = fda_pkg::PH_TAG_HDR; count_in = '0;
               end
            end
            fda_pkg::PH_TAG_HDR: begin
               if (count_ff == 32'd0) tag_kind_in = byte_data;
               else if (count_ff <= 32'd3) tag_len_in = {tag_len_ff[15:0], byte_data};
               else if (count_ff <= 32'd6) tag_time_in = {8'd0, tag_time_ff[15:0], byte_data};
               else if (count_ff == 32'd7) tag_time_in = {byte_data, tag_time_ff[23:0]};
               count_in = count_inc;
               if (count_inc >= 32'd11) begin
                  count_in = '0; pkt_in = '0; comp_in = '0;
                  if (tag_len_ff == 24'd0) phase_in = fda_pkg::PH_PREV_SIZE;
                  else if (tag_kind_ff == fda_pkg::TAG_VIDEO) phase_in = fda_pkg::PH_VID_HEAD;
                  else if (tag_kind_ff == fda_pkg::TAG_AUDIO) phase_in = fda_pkg::PH_AUD_HEAD;
                  else phase_in = fda_pkg::PH_SKIP;
               end
            end
            default: body = 1'b1;
         endcase
         if (body) begin
            case (phase_ff)
               fda_pkg::PH_VID_HEAD: begin
                  if (count_ff == 32'd0) begin
                     if (byte_data[3:0] != fda_pkg::CODEC_AVC) phase_in = fda_pkg::PH_SKIP;
                  end else if (count_ff == 32'd1) begin
                     pkt_in = byte_data;
                  end else begin
                     comp_in = {comp_ff[15:0], byte_data};
                     if (count_ff == 32'd4) begin
                        if (pkt_ff == 8'd0) phase_in = fda_pkg::PH_CFG_HEAD;
                        else if (pkt_ff == 8'd1) begin
                           phase_in = fda_pkg::PH_NAL_LEN; sub_in = '0; nal_rem_in = '0;
                        end else phase_in = fda_pkg::PH_SKIP;
                     end
                  end
               end
               fda_pkg::PH_CFG_HEAD: begin
                  if (count_ff == 32'd9) nal_bytes_in = {1'b0, byte_data[1:0]} + 3'd1;
                  else if (count_ff == 32'd11) ps_len_in = {8'd0, byte_data};
                  else if (count_ff == 32'd12) begin
                     ps_len_in = ps_full;
                     cmd_valid = video_enable; cmd.kind = fda_pkg::CMD_START;
                     if (ps_full != 16'd0) begin
                        nal_rem_in = {16'd0, ps_full}; phase_in = fda_pkg::PH_CFG_SPS;
                     end else begin
                        phase_in = fda_pkg::PH_CFG_PPS_HEAD; sub_in = '0;
                     end
                  end
               end
               fda_pkg::PH_CFG_SPS, fda_pkg::PH_CFG_PPS, fda_pkg::PH_NAL_DATA: begin
                  cmd_valid = video_enable;
                  nal_rem_in = nal_rem_ff - 32'd1;
                  if (nal_rem_ff == 32'd1) begin
                     sub_in = '0;
                     case (phase_ff)
                        fda_pkg::PH_CFG_SPS: phase_in = fda_pkg::PH_CFG_PPS_HEAD;
                        fda_pkg::PH_CFG_PPS: phase_in = fda_pkg::PH_SKIP;
                        default:             phase_in = fda_pkg::PH_NAL_LEN;
                     endcase
                  end
               end
               fda_pkg::PH_CFG_PPS_HEAD: begin
                  if (sub_ff == 3'd1) ps_len_in = {8'd0, byte_data};
                  else if (sub_ff == 3'd2) begin
                     ps_len_in = ps_full;
                     cmd_valid = video_enable; cmd.kind = fda_pkg::CMD_START;
                     if (ps_full != 16'd0) begin
                        nal_rem_in = {16'd0, ps_full}; phase_in = fda_pkg::PH_CFG_PPS;
                     end else phase_in = fda_pkg::PH_SKIP;
                  end
                  if (sub_ff != 3'd7) sub_in = sub_inc;
               end
               fda_pkg::PH_NAL_LEN: begin
                  nal_rem_in = nal_shift;
                  sub_in = sub_inc;
                  if (sub_inc >= nal_bytes_ff) begin
                     cmd_valid = video_enable; cmd.kind = fda_pkg::CMD_START;
                     sub_in = '0;
                     if (nal_shift != 32'd0) phase_in = fda_pkg::PH_NAL_DATA;
                  end
               end
               fda_pkg::PH_AUD_HEAD: begin
                  if (count_ff == 32'd0) begin
                     if (byte_data[7:4] != fda_pkg::FMT_AAC) phase_in = fda_pkg::PH_SKIP;
                  end else begin
                     pkt_in = byte_data;
                     if (byte_data == 8'd0) phase_in = fda_pkg::PH_AUD_CFG;
                     else if (byte_data == 8'd1) begin
                        cmd_valid = audio_enable; cmd.kind = fda_pkg::CMD_ADTS;
                        cmd.stream = 1'b1; phase_in = fda_pkg::PH_AUD_DATA;
                     end else phase_in = fda_pkg::PH_SKIP;
                  end
               end
               fda_pkg::PH_AUD_CFG: begin
                  if (count_ff == 32'd2) begin
                     prof_in = 2'(byte_data[4:3] - 2'd1);
                     rate_in = {byte_data[2:0], 1'b0};
                  end else begin
                     rate_in = {rate_ff[3:1], rate_ff[0] | byte_data[7]};
                     chan_in = byte_data[5:3];
                     phase_in = fda_pkg::PH_SKIP;
                  end
               end
               fda_pkg::PH_AUD_DATA: begin
                  cmd_valid = audio_enable; cmd.stream = 1'b1;
               end
               default: ;
            endcase
            count_in = count_inc;
            if (count_inc >= {8'd0, tag_len_ff}) begin
               phase_in = fda_pkg::PH_PREV_SIZE; count_in = '0;
            end
         end
      end
      if (cmd.stream) cmd.cts = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fda_pkg::PH_FILE_HDR; count_ff <= '0; hdr_len_ff <= '0;
         tag_kind_ff <= '0; tag_len_ff <= '0; tag_time_ff <= '0; pkt_ff <= '0;
         comp_ff <= '0; nal_bytes_ff <= 3'd4; nal_rem_ff <= '0; ps_len_ff <= '0;
         prof_ff <= '0; rate_ff <= '0; chan_ff <= '0; sub_ff <= '0;
      end else begin
         phase_ff <= phase_in; count_ff <= count_in; hdr_len_ff <= hdr_len_in;
         tag_kind_ff <= tag_kind_in; tag_len_ff <= tag_len_in; tag_time_ff <= tag_time_in;
         pkt_ff <= pkt_in; comp_ff <= comp_in; nal_bytes_ff <= nal_bytes_in;
         nal_rem_ff <= nal_rem_in; ps_len_ff <= ps_len_in; prof_ff <= prof_in;
         rate_ff <= rate_in; chan_ff <= chan_in; sub_ff <= sub_in;
      end
   end

endmodule

// File: rtl/fda_queue.sv
// Short command FIFO between parser and emitter.
// Depends on fda_pkg.
module fda_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fda_pkg::cmd_type  push_data,
   input  logic              pop,
   output logic              empty,
   output logic              full,
   output fda_pkg::cmd_type  head
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   fda_pkg::cmd_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      bump = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? bump(wr_ff) : wr_ff;
      rd_in = pop ? bump(rd_ff) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/fda_emit.sv
// Back end: expands a command into 1, 4 or 7 output bytes and drives the output register.
// Depends on fda_pkg.
module fda_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_present,
   input  fda_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_stream_kind,
   output logic              rsp_unit_start,
   output logic [31:0]       rsp_unit_dts,
   output logic [23:0]       rsp_unit_cts,
   output logic              rsp_last_of_run
);

   logic [2:0] idx_ff, idx_in;
   logic       val_ff, val_in;
   logic [7:0] byte_ff, byte_in;
   logic       kind_ff, start_ff, last_ff;
   logic [31:0] dts_ff;
   logic [23:0] cts_ff;
   logic       load;
   logic [7:0] sel_byte;
   logic       sel_last;

   assign load = cmd_present && (!val_ff || !rsp_stall);

   always_comb begin
      sel_byte = cmd.data;
      sel_last = 1'b1;
      case (cmd.kind)
         fda_pkg::CMD_START: begin
            sel_byte = (idx_ff == 3'(fda_pkg::START_BYTES - 1)) ? 8'h01 : 8'h00;
            sel_last = (idx_ff == 3'(fda_pkg::START_BYTES - 1));
         end
         fda_pkg::CMD_ADTS: begin
            sel_last = (idx_ff == 3'(fda_pkg::ADTS_BYTES - 1));
            case (idx_ff)
               3'd0: sel_byte = 8'hFF;
               3'd1: sel_byte = 8'hF1;
               3'd2: sel_byte = {cmd.profile, cmd.rate_index, 1'b0, cmd.channels[2]};
               3'd3: sel_byte = {cmd.channels[1:0], 4'd0, cmd.adts_len[12:11]};
               3'd4: sel_byte = cmd.adts_len[10:3];
               3'd5: sel_byte = {cmd.adts_len[2:0], 5'h1F};
               default: sel_byte = 8'hFC;
            endcase
         end
         default: ;
      endcase
      cmd_pop = load && sel_last;
      idx_in = load ? (sel_last ? 3'd0 : idx_ff + 3'd1) : idx_ff;
      val_in = load ? 1'b1 : (val_ff && rsp_stall);
      byte_in = sel_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0; val_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in; val_ff <= val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in; kind_ff <= cmd.stream; start_ff <= (idx_ff == 3'd0) &&
            (cmd.kind != fda_pkg::CMD_BYTE);
         last_ff <= sel_last; dts_ff <= cmd.dts; cts_ff <= cmd.cts;
      end
   end

   assign rsp_valid = val_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_stream_kind = kind_ff;
   assign rsp_unit_start = start_ff;
   assign rsp_unit_dts = dts_ff;
   assign rsp_unit_cts = cts_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// File: rtl/flv_demux_annexb_adts_top.sv
// FLV demultiplexer to H.264 Annex B and AAC ADTS elementary streams.
// Path: the parser classifies and writes the command queue in the accepting cycle; the emitter
// then loads the output register from the queue head unless rsp_stall or earlier commands hold it.
// Throughput: one request per cycle for payload bytes while the command queue is not full; a
// start code expands to 4 and an ADTS header to 7 output bytes, absorbed by the command queue.
// Reset: synchronous, active high; parser returns to the file header phase, registers to 1.
module flv_demux_annexb_adts_top #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_stream_kind,
   output logic        rsp_unit_start,
   output logic [31:0] rsp_unit_dts,
   output logic [23:0] rsp_unit_cts,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic        csr_data
);

   logic video_en_ff, audio_en_ff;
   logic accept;
   logic cmd_valid, q_empty, q_full, q_pop;
   fda_pkg::cmd_type cmd, q_head;

   // registers are written at any time; the parser stalls only on a full queue
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         video_en_ff <= 1'b1; audio_en_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == fda_pkg::CSR_VIDEO_EN) video_en_ff <= csr_data;
         else audio_en_ff <= csr_data;
      end
   end

   assign req_stall = q_full;
   assign accept = req_valid && !req_stall;

   fda_parse u_parse (
      .clock(clock), .reset(reset), .byte_valid(accept), .byte_data(req_file_byte),
      .video_enable(video_en_ff), .audio_enable(audio_en_ff),
      .cmd_valid(cmd_valid), .cmd(cmd)
   );

   fda_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(cmd_valid), .push_data(cmd), .pop(q_pop),
      .empty(q_empty), .full(q_full), .head(q_head)
   );

   fda_emit u_emit (
      .clock(clock), .reset(reset), .cmd_present(!q_empty), .cmd(q_head), .cmd_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_stream_kind(rsp_stream_kind), .rsp_unit_start(rsp_unit_start),
      .rsp_unit_dts(rsp_unit_dts), .rsp_unit_cts(rsp_unit_cts),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // no push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> !q_full) else $error("command queue overflow");
   // no pop from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("command queue underflow");
   // audio bytes never carry a composition offset
   a_audio_cts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_kind) |-> (rsp_unit_cts == 24'd0))
      else $error("audio result with nonzero cts");

endmodule
